>>> hw/rtl/shb_pkg.sv
`default_nettype none
package shb_pkg;

   localparam int unsigned WORDS  = 8;
   localparam int unsigned ROUNDS = 12;

   typedef logic [WORDS-1:0][63:0] blk_type;

   typedef struct packed {
      logic [63:0] message_word;
      logic [3:0]  byte_count;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_INIT, ST_SUB, ST_KEY, ST_FIN, ST_ADD, ST_OUT
   } state_type;

   // Which compression is running: message block, padded block, g0(N), g0(Sigma).
   typedef enum logic [1:0] {PH_BLOCK, PH_PAD, PH_GN, PH_GS} phase_type;

   localparam logic CSR_MODE_256 = 1'b0;

   localparam logic [7:0] SBOX [256] = '{
      8'd252,8'd238,8'd221,8'd17,8'd207,8'd110,8'd49,8'd22,
      8'd251,8'd196,8'd250,8'd218,8'd35,8'd197,8'd4,8'd77,
      8'd233,8'd119,8'd240,8'd219,8'd147,8'd46,8'd153,8'd186,
      8'd23,8'd54,8'd241,8'd187,8'd20,8'd205,8'd95,8'd193,
      8'd249,8'd24,8'd101,8'd90,8'd226,8'd92,8'd239,8'd33,
      8'd129,8'd28,8'd60,8'd66,8'd139,8'd1,8'd142,8'd79,
      8'd5,8'd132,8'd2,8'd174,8'd227,8'd106,8'd143,8'd160,
      8'd6,8'd11,8'd237,8'd152,8'd127,8'd212,8'd211,8'd31,
      8'd235,8'd52,8'd44,8'd81,8'd234,8'd200,8'd72,8'd171,
      8'd242,8'd42,8'd104,8'd162,8'd253,8'd58,8'd206,8'd204,
      8'd181,8'd112,8'd14,8'd86,8'd8,8'd12,8'd118,8'd18,
      8'd191,8'd114,8'd19,8'd71,8'd156,8'd183,8'd93,8'd135,
      8'd21,8'd161,8'd150,8'd41,8'd16,8'd123,8'd154,8'd199,
      8'd243,8'd145,8'd120,8'd111,8'd157,8'd158,8'd178,8'd177,
      8'd50,8'd117,8'd25,8'd61,8'd255,8'd53,8'd138,8'd126,
      8'd109,8'd84,8'd198,8'd128,8'd195,8'd189,8'd13,8'd87,
      8'd223,8'd245,8'd36,8'd169,8'd62,8'd168,8'd67,8'd201,
      8'd215,8'd121,8'd214,8'd246,8'd124,8'd34,8'd185,8'd3,
      8'd224,8'd15,8'd236,8'd222,8'd122,8'd148,8'd176,8'd188,
      8'd220,8'd232,8'd40,8'd80,8'd78,8'd51,8'd10,8'd74,
      8'd167,8'd151,8'd96,8'd115,8'd30,8'd0,8'd98,8'd68,
      8'd26,8'd184,8'd56,8'd130,8'd100,8'd159,8'd38,8'd65,
      8'd173,8'd69,8'd70,8'd146,8'd39,8'd94,8'd85,8'd47,
      8'd140,8'd163,8'd165,8'd125,8'd105,8'd213,8'd149,8'd59,
      8'd7,8'd88,8'd179,8'd64,8'd134,8'd172,8'd29,8'd247,
      8'd48,8'd55,8'd107,8'd228,8'd136,8'd217,8'd231,8'd137,
      8'd225,8'd27,8'd131,8'd73,8'd76,8'd63,8'd248,8'd254,
      8'd141,8'd83,8'd170,8'd144,8'd202,8'd216,8'd133,8'd97,
      8'd32,8'd113,8'd103,8'd164,8'd45,8'd43,8'd9,8'd91,
      8'd203,8'd155,8'd37,8'd208,8'd190,8'd229,8'd108,8'd82,
      8'd89,8'd166,8'd116,8'd210,8'd230,8'd244,8'd180,8'd192,
      8'd209,8'd102,8'd175,8'd194,8'd57,8'd75,8'd99,8'd182
   };

   localparam logic [63:0] AMAT [64] = '{
      64'h8e20faa72ba0b470,64'h47107ddd9b505a38,64'had08b0e0c3282d1c,64'hd8045870ef14980e,
      64'h6c022c38f90a4c07,64'h3601161cf205268d,64'h1b8e0b0e798c13c8,64'h83478b07b2468764,
      64'ha011d380818e8f40,64'h5086e740ce47c920,64'h2843fd2067adea10,64'h14aff010bdd87508,
      64'h0ad97808d06cb404,64'h05e23c0468365a02,64'h8c711e02341b2d01,64'h46b60f011a83988e,
      64'h90dab52a387ae76f,64'h486dd4151c3dfdb9,64'h24b86a840e90f0d2,64'h125c354207487869,
      64'h092e94218d243cba,64'h8a174a9ec8121e5d,64'h4585254f64090fa0,64'haccc9ca9328a8950,
      64'h9d4df05d5f661451,64'hc0a878a0a1330aa6,64'h60543c50de970553,64'h302a1e286fc58ca7,
      64'h18150f14b9ec46dd,64'h0c84890ad27623e0,64'h0642ca05693b9f70,64'h0321658cba93c138,
      64'h86275df09ce8aaa8,64'h439da0784e745554,64'hafc0503c273aa42a,64'hd960281e9d1d5215,
      64'he230140fc0802984,64'h71180a8960409a42,64'hb60c05ca30204d21,64'h5b068c651810a89e,
      64'h456c34887a3805b9,64'hac361a443d1c8cd2,64'h561b0d22900e4669,64'h2b838811480723ba,
      64'h9bcf4486248d9f5d,64'hc3e9224312c8c1a0,64'heffa11af0964ee50,64'hf97d86d98a327728,
      64'he4fa2054a80b329c,64'h727d102a548b194e,64'h39b008152acb8227,64'h9258048415eb419d,
      64'h492c024284fbaec0,64'haa16012142f35760,64'h550b8e9e21f7a530,64'ha48b474f9ef5dc18,
      64'h70a6a56e2440598e,64'h3853dc371220a247,64'h1ca76e95091051ad,64'h0edd37c48a08a6d8,
      64'h07e095624504536c,64'h8d70c431ac02a736,64'hc83862965601dd1b,64'h641c314b2b8ee083
   };

   localparam logic [63:0] RC [ROUNDS][WORDS] = '{
      '{64'hdd806559f2a64507,64'h05767436cc744d23,64'ha2422a08a460d315,64'h4b7ce09192676901,
        64'h714eb88d7585c4fc,64'h2f6a76432e45d016,64'hebcb2f81c0657c1f,64'hb1085bda1ecadae9},
      '{64'he679047021b19bb7,64'h55dda21bd7cbcd56,64'h5cb561c2db0aa7ca,64'h9ab5176b12d69958,
        64'h61d55e0f16b50131,64'hf3feea720a232b98,64'h4fe39d460f70b5d7,64'h6fa3b58aa99d2f1a},
      '{64'h991e96f50aba0ab2,64'hc2b6f443867adb31,64'hc1c93a376062db09,64'hd3e20fe490359eb1,
        64'hf2ea7514b1297b7b,64'h06f15e5f529c1f8b,64'h0a39fc286a3d8435,64'hf574dcac2bce2fc7},
      '{64'h220cbebc84e3d12e,64'h3453eaa193e837f1,64'hd8b71333935203be,64'ha9d72c82ed03d675,
        64'h9d721cad685e353f,64'h488e857e335c3c7d,64'hf948e1a05d71e4dd,64'hef1fdfb3e81566d2},
      '{64'h601758fd7c6cfe57,64'h7a56a27ea9ea63f5,64'hdfff00b723271a16,64'hbfcd1747253af5a3,
        64'h359e35d7800fffbd,64'h7f151c1f1686104a,64'h9a3f410c6ca92363,64'h4bea6bacad474799},
      '{64'hfa68407a46647d6e,64'hbf71c57236904f35,64'h0af21f66c2bec6b6,64'hcffaa6b71c9ab7b4,
        64'h187f9ab49af08ec6,64'h2d66c4f95142a46c,64'h6fa4c33b7a3039c0,64'hae4faeae1d3ad3d9},
      '{64'h8886564d3a14d493,64'h3517454ca23c4af3,64'h06476983284a0504,64'h0992abc52d822c37,
        64'hd3473e33197a93c9,64'h399ec6c7e6bf87c9,64'h51ac86febf240954,64'hf4c70e16eeaac5ec},
      '{64'ha47f0dd4bf02e71e,64'h36acc2355951a8d9,64'h69d18d2bd1a5c42f,64'hf4892bcb929b0690,
        64'h89b4443b4ddbc49a,64'h4eb7f8719c36de1e,64'h03e7aa020c6e4141,64'h9b1f5b424d93c9a7},
      '{64'h7261445183235adb,64'h0e38dc92cb1f2a60,64'h7b2b8a9aa6079c54,64'h800a440bdbb2ceb1,
        64'h3cd955b7e00d0984,64'h3a7d3a1b25894224,64'h944c9ad8ec165fde,64'h378f5a541631229b},
      '{64'h74b4c7fb98459ced,64'h3698fad1153bb6c3,64'h7a1e6c303b7652f4,64'h9fe76702af69334b,
        64'h1fffe18a1b336103,64'h8941e71cff8a78db,64'h382ae548b2e4f3f3,64'habbedea680056f52},
      '{64'h6bcaa4cd81f32d1b,64'hdea2594ac06fd85d,64'hefbacd1d7d476e98,64'h8a1d71efea48b9ca,
        64'h2001802114846679,64'hd8fa6bbbebab0761,64'h3002c6cd635afe94,64'h7bcd9ed0efc889fb},
      '{64'h48bc924af11bd720,64'hfaf417d5d9b21b99,64'he71da4aa88e12852,64'h5d80ef9d1891cc86,
        64'hf82012d430219f9b,64'hcda43c32bcdf1d77,64'hd21380b00449b17a,64'h378ee767f11631ba}
   };

   // Linear map L: each set input bit folds in one row of the matrix.
   function automatic logic [63:0] lin_map(input logic [63:0] a);
      logic [63:0] acc;
      acc = '0;
      for (int j = 0; j < 64; j++) begin
         if (a[j]) begin
            acc = acc ^ AMAT[63-j];
         end
      end
      return acc;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/shb_lps.sv
`default_nettype none
module shb_lps (
   input  wire shb_pkg::blk_type din,
   output shb_pkg::blk_type      dout
);
   import shb_pkg::*;

   // Byte i of every input word, substituted, forms output word i before L.
   always_comb begin
      logic [63:0] acc;
      for (int i = 0; i < WORDS; i++) begin
         for (int b = 0; b < WORDS; b++) begin
            acc[8*b +: 8] = SBOX[din[b][8*i +: 8]];
         end
         dout[i] = lin_map(acc);
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/streebog_hash_engine.sv
`default_nettype none
// Hash engine for the 512/256-bit GOST R 34.11-2012 function.
// Message beats arrive on the req_ channel: eight little-endian bytes, a byte
// count and a last mark. A beat is taken when req_valid is high and req_stall
// low; req_stall stays high while the engine works on a beat.
// A beat that neither completes a 64-byte block nor is the last leaves the
// engine ready for the next beat. A beat that completes a block runs a
// compression through the single shared LPS unit (one key-init pass plus two
// LPS passes per round over twelve rounds and a feed-forward), then
// word-serial 512-bit additions for N and Sigma. The last beat adds a pad
// step, another compression with its additions and two more compressions for
// the finalisation, after which the digest is offered.
// The digest leaves on the rsp_ channel as eight beats, word 0 first, straight
// from the chaining register; a stalled rsp_ beat simply holds until taken.
// After the eighth beat the engine restarts with the IV of the current mode.
// Writing mode_256 (address 0) also restarts the message. Reset clears the
// mode, the chaining value and the counters and leaves the engine idle.
module streebog_hash_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire shb_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output shb_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic             paddr,
   input  wire logic [31:0]      pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import shb_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [3:0]  ctr_ff, ctr_in;
   logic        mode_ff, mode_in;
   logic        last_ff, last_in;
   logic [6:0]  fill_ff, fill_in;
   logic        cn_ff, cn_in;
   logic        cs_ff, cs_in;
   blk_type     h_ff, h_in;
   blk_type     n_ff, n_in;
   blk_type     sig_ff, sig_in;
   blk_type     buf_ff, buf_in;
   blk_type     key_ff, key_in;
   blk_type     st_ff, st_in;
   blk_type     lps_din, lps_dout;
   blk_type     msg;

   logic        req_fire, rsp_fire, cfg_wr;
   logic [3:0]  cnt_eff;
   logic [63:0] word_masked;
   logic [2:0]  widx;
   logic [6:0]  fill_new;
   logic [2:0]  aidx;
   logic [63:0] addend;
   logic [64:0] sum_n, sum_s;

   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;
   assign cfg_wr   = psel && penable && pwrite && pready && (paddr == CSR_MODE_256);
   assign pready   = 1'b1;
   assign prdata   = {31'b0, mode_ff};

   shb_lps u_lps (
      .din  (lps_din),
      .dout (lps_dout)
   );

   // Beat formatting: a short count only counts on the last beat.
   always_comb begin
      cnt_eff = (!req_data.last_item || req_data.byte_count > 4'd8) ? 4'd8
                                                                     : req_data.byte_count;
      for (int b = 0; b < 8; b++) begin
         word_masked[8*b +: 8] = (4'(b) < cnt_eff) ? req_data.message_word[8*b +: 8] : 8'h00;
      end
      widx     = fill_ff[5:3];
      fill_new = {1'b0, widx, 3'b000} + {3'b000, cnt_eff};
      aidx     = ctr_ff[2:0];
   end

   // Operand selection around the LPS unit.
   always_comb begin
      case (phase_ff)
         PH_GN:   msg = n_ff;
         PH_GS:   msg = sig_ff;
         default: msg = buf_ff;
      endcase
      case (state_ff)
         ST_INIT: lps_din = h_ff ^ ((phase_ff == PH_BLOCK || phase_ff == PH_PAD) ? n_ff : '0);
         ST_SUB:  lps_din = st_ff;
         default: begin
            for (int k = 0; k < WORDS; k++) begin
               lps_din[k] = key_ff[k] ^ RC[ctr_ff][k];
            end
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (fill_new[6]) begin
                  state_in = ST_INIT;
               end else if (req_data.last_item) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD:  state_in = ST_INIT;
         ST_INIT: state_in = ST_SUB;
         ST_SUB:  state_in = ST_KEY;
         ST_KEY: begin
            state_in = (ctr_ff == 4'(ROUNDS - 1)) ? ST_FIN : ST_SUB;
         end
         ST_FIN: begin
            case (phase_ff)
               PH_GN:   state_in = ST_INIT;
               PH_GS:   state_in = ST_OUT;
               default: state_in = ST_ADD;
            endcase
         end
         ST_ADD: begin
            if (aidx == 3'd7) begin
               if (phase_ff == PH_PAD) begin
                  state_in = ST_INIT;
               end else begin
                  state_in = last_ff ? ST_PAD : ST_IDLE;
               end
            end
         end
         ST_OUT: begin
            if (rsp_fire && aidx == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_OUT:  rsp_valid = 1'b1;
         default: req_stall = 1'b1;
      endcase
      rsp_data.digest_word = h_ff[aidx];
      rsp_data.word_index  = aidx;
      rsp_data.last_word   = (aidx == 3'd7);
   end

   // Datapath next values.
   always_comb begin
      phase_in = phase_ff;
      ctr_in   = ctr_ff;
      mode_in  = mode_ff;
      last_in  = last_ff;
      fill_in  = fill_ff;
      cn_in    = cn_ff;
      cs_in    = cs_ff;
      h_in     = h_ff;
      n_in     = n_ff;
      sig_in   = sig_ff;
      buf_in   = buf_ff;
      key_in   = key_ff;
      st_in    = st_ff;
      addend   = '0;
      sum_n    = '0;
      sum_s    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               buf_in[widx] = word_masked;
               last_in      = req_data.last_item;
               phase_in     = PH_BLOCK;
               ctr_in       = '0;
               fill_in      = fill_new[6] ? 7'd0 : fill_new;
            end
         end
         ST_PAD: begin
            // A 0x01 byte follows the data; words above it are cleared.
            for (int k = 0; k < WORDS; k++) begin
               if (3'(k) == fill_ff[5:3]) begin
                  buf_in[k] = (fill_ff[2:0] == 3'd0) ? 64'd1
                              : (buf_ff[k] | (64'd1 << {fill_ff[2:0], 3'b000}));
               end else if (3'(k) > fill_ff[5:3]) begin
                  buf_in[k] = '0;
               end
            end
            phase_in = PH_PAD;
            ctr_in   = '0;
         end
         ST_INIT: begin
            key_in = lps_dout;
            st_in  = lps_dout ^ msg;
            ctr_in = '0;
         end
         ST_SUB: begin
            st_in = lps_dout;
         end
         ST_KEY: begin
            key_in = lps_dout;
            st_in  = st_ff ^ lps_dout;
            ctr_in = ctr_ff + 4'd1;
         end
         ST_FIN: begin
            h_in   = h_ff ^ st_ff ^ msg;
            ctr_in = '0;
            cn_in  = 1'b0;
            cs_in  = 1'b0;
            if (phase_ff == PH_GN) begin
               phase_in = PH_GS;
            end
         end
         ST_ADD: begin
            // One 64-bit word of N and of Sigma per cycle, carries held.
            if (aidx == 3'd0) begin
               addend = (phase_ff == PH_BLOCK) ? 64'd512 : {54'b0, fill_ff, 3'b000};
            end
            sum_n       = {1'b0, n_ff[aidx]} + {1'b0, addend} + {64'b0, cn_ff};
            sum_s       = {1'b0, sig_ff[aidx]} + {1'b0, buf_ff[aidx]} + {64'b0, cs_ff};
            n_in[aidx]  = sum_n[63:0];
            sig_in[aidx] = sum_s[63:0];
            cn_in       = sum_n[64];
            cs_in       = sum_s[64];
            ctr_in      = ctr_ff + 4'd1;
            if (aidx == 3'd7) begin
               ctr_in = '0;
               if (phase_ff == PH_PAD) begin
                  phase_in = PH_GN;
               end
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               ctr_in = ctr_ff + 4'd1;
               if (aidx == 3'd7) begin
                  ctr_in  = '0;
                  h_in    = mode_ff ? {WORDS{64'h0101010101010101}} : '0;
                  n_in    = '0;
                  sig_in  = '0;
                  fill_in = '0;
               end
            end
         end
         default: begin
            ctr_in = '0;
         end
      endcase
      if (cfg_wr) begin
         mode_in = pwdata[0];
         h_in    = pwdata[0] ? {WORDS{64'h0101010101010101}} : '0;
         n_in    = '0;
         sig_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_BLOCK;
         ctr_ff   <= '0;
         mode_ff  <= 1'b0;
         last_ff  <= 1'b0;
         fill_ff  <= '0;
         cn_ff    <= 1'b0;
         cs_ff    <= 1'b0;
         h_ff     <= '0;
         n_ff     <= '0;
         sig_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         ctr_ff   <= ctr_in;
         mode_ff  <= mode_in;
         last_ff  <= last_in;
         fill_ff  <= fill_in;
         cn_ff    <= cn_in;
         cs_ff    <= cs_in;
         h_ff     <= h_in;
         n_ff     <= n_in;
         sig_ff   <= sig_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      key_ff <= key_in;
      st_ff  <= st_in;
   end

endmodule
`default_nettype wire
